// File: rtl/vna_pkg.sv
`default_nettype none
package vna_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;

    // Coordinates keep at most 16 bits, taken from the low end of each field.
    localparam int CW          = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int IDX_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int FIELD_IDX_W = 6;
    localparam int VTX_W       = 3 * CW;
    localparam int DIFF_W      = CW + 1;
    localparam int N_W         = 2 * DIFF_W + 1;
    localparam int SUM_W       = 48;
    localparam int SUMS_W      = 3 * SUM_W;
    localparam int MAG_W       = 48;
    localparam int MAC_W       = 32;
    localparam int ACC_W       = 64;
    localparam int LEN_W       = 32;
    localparam int NUM_W       = 46;
    localparam int UNIT_W      = 16;
    localparam int UNIT_ONE    = 16384;
    localparam int IN_W        = 72;
    localparam int OUT_W       = 48;
    localparam int CMD_W       = 2;

    localparam logic [MAG_W-1:0] NORM_HI = MAG_W'(1) << 30;
    localparam logic [MAG_W-1:0] NORM_LO = MAG_W'(1) << 29;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_TRI   = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRI_LD,
        ST_TRI_DIFF,
        ST_TRI_MUL,
        ST_TRI_RMW,
        ST_RD_SUM,
        ST_RD_MAG,
        ST_RD_MAX,
        ST_RD_SHIFT,
        ST_RD_SQ,
        ST_RD_SQRT,
        ST_RD_DSET,
        ST_RD_DIV,
        ST_RD_DONE
    } state_t;

    typedef struct packed {
        logic acc_en;
        logic acc_load;
        logic acc_sub;
    } mac_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/vna_mac.sv
`default_nettype none
module vna_mac (
    input  wire                                 clk,
    input  vna_pkg::mac_ctrl_t                  ctrl,
    input  wire logic signed [vna_pkg::MAC_W-1:0] op_a,
    input  wire logic signed [vna_pkg::MAC_W-1:0] op_b,
    output logic signed [vna_pkg::ACC_W-1:0]    acc
);
    import vna_pkg::*;

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // The control word acts on the product registered in the cycle before.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (ctrl.acc_en)
        begin
            if (ctrl.acc_load)
                acc_reg <= prod_reg;
            else if (ctrl.acc_sub)
                acc_reg <= acc_reg - prod_reg;
            else
                acc_reg <= acc_reg + prod_reg;
        end
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

// File: rtl/vertex_normal_accumulator_unit.sv
`default_nettype none
// Channel  Direction  tdata fields (low bit up)                          tuser
// s_*      in         vertex_slot, coord_x, coord_y, coord_z,            command
//                     corner_a, corner_b, corner_c (72 bits)
// m_*      out        unit_x, unit_y, unit_z (48 bits)                   zero_length
//
// Clear and load vertex complete while the unit stays idle. Add triangle reads the
// corner vertices from the vertex memory, forms the edge differences, runs the
// cross products on the shared multiplier and does three read-modify-writes of
// the sum memory. Read normal normalizes the sum by shifting one bit per cycle
// until the largest magnitude is in range, squares the components on the shared
// multiplier, takes the square root one bit per cycle and divides each component
// by the length, one quotient bit per cycle; a zero sum skips these last steps.
// Reset is asynchronous and active low; the normal sums read as zero after reset
// through per-entry valid bits, and a clear command drops all of them at once.
// A finished normal waits in the output register while new items are taken; a
// second normal stalls in its final state until the first one is taken.
module vertex_normal_accumulator_unit (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    // vertex_slot, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
    input  wire [vna_pkg::IN_W-1:0]     s_tdata,
    // command
    input  wire [vna_pkg::CMD_W-1:0]    s_tuser,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    // unit_x, unit_y, unit_z
    output logic [vna_pkg::OUT_W-1:0]   m_tdata,
    // zero_length
    output logic [0:0]                  m_tuser
);
    import vna_pkg::*;

    // Input fields.
    logic                   in_acc;
    cmd_t                   in_cmd;
    logic [FIELD_IDX_W-1:0] in_slot;
    logic [FIELD_IDX_W-1:0] in_corner [3];
    logic [15:0]            in_coord  [3];
    logic                   in_slot_ok;
    logic                   in_corners_ok;

    assign in_acc       = s_tvalid && s_tready;
    assign in_cmd       = cmd_t'(s_tuser);
    assign in_slot      = s_tdata[5:0];
    assign in_coord[0]  = s_tdata[21:6];
    assign in_coord[1]  = s_tdata[37:22];
    assign in_coord[2]  = s_tdata[53:38];
    assign in_corner[0] = s_tdata[59:54];
    assign in_corner[1] = s_tdata[65:60];
    assign in_corner[2] = s_tdata[71:66];

    assign in_slot_ok    = {1'b0, in_slot} < 7'(MAX_VERTICES);
    assign in_corners_ok = ({1'b0, in_corner[0]} < 7'(MAX_VERTICES))
                        && ({1'b0, in_corner[1]} < 7'(MAX_VERTICES))
                        && ({1'b0, in_corner[2]} < 7'(MAX_VERTICES));

    // Control state.
    state_t            state_reg, state_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [1:0]        j_reg, j_next;
    logic [MAX_VERTICES-1:0] valid_reg;
    logic              m_tvalid_reg;
    logic              out_free;
    logic              out_load;

    // Payload registers.
    logic [FIELD_IDX_W-1:0]   slot_reg;
    logic [FIELD_IDX_W-1:0]   corner_reg [3];
    logic [VTX_W-1:0]         vtx_reg    [3];
    logic signed [DIFF_W-1:0] u_reg      [3];
    logic signed [DIFF_W-1:0] v_reg      [3];
    logic signed [N_W-1:0]    n_reg      [3];
    logic [MAG_W-1:0]         mag_reg    [3];
    logic                     sign_reg   [3];
    logic [MAG_W-1:0]         big_reg;
    logic [ACC_W-1:0]         sqv_reg;
    logic [ACC_W-1:0]         res_reg;
    logic [ACC_W-1:0]         bit_reg;
    logic [LEN_W:0]           rem_reg;
    logic [15:0]              numlo_reg;
    logic [15:0]              q_reg;
    logic [UNIT_W-1:0]        unit_reg   [3];
    logic                     zero_reg;
    logic [OUT_W-1:0]         m_tdata_reg;
    logic                     m_tuser_reg;

    // Memories.
    logic [VTX_W-1:0]  vmem [MAX_VERTICES];
    logic [VTX_W-1:0]  vrd_reg;
    logic [IDX_W-1:0]  vrd_addr;
    logic              vwr_en;
    logic [VTX_W-1:0]  vwr_data;

    logic [SUMS_W-1:0] smem [MAX_VERTICES];
    logic [SUMS_W-1:0] srd_reg;
    logic [IDX_W-1:0]  srd_addr;
    logic              swr_en;
    logic [SUMS_W-1:0] swr_data;

    // Shared multiplier.
    mac_ctrl_t               mac_ctrl;
    logic signed [MAC_W-1:0] mac_a;
    logic signed [MAC_W-1:0] mac_b;
    logic signed [ACC_W-1:0] mac_acc;

    vna_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (mac_acc)
    );

    assign vwr_en   = in_acc && (in_cmd == CMD_LOAD) && in_slot_ok;
    assign vwr_data = {in_coord[2][CW-1:0], in_coord[1][CW-1:0], in_coord[0][CW-1:0]};

    always_ff @(posedge clk)
    begin
        if (vwr_en)
            vmem[in_slot[IDX_W-1:0]] <= vwr_data;
        vrd_reg <= vmem[vrd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (swr_en)
            smem[srd_addr] <= swr_data;
        srd_reg <= smem[srd_addr];
    end

    // Saturating update of one corner's sum; an entry without its valid bit reads
    // as zero.
    logic [1:0]  rmw_corner;
    logic        rmw_valid;
    assign rmw_corner = cnt_reg[2:1];
    assign rmw_valid  = valid_reg[srd_addr];

    always_comb
    begin
        logic signed [SUM_W-1:0] old_c;
        logic signed [SUM_W:0]   sum_c;
        for (int c = 0; c < 3; c++)
        begin
            old_c = rmw_valid ? $signed(srd_reg[c*SUM_W +: SUM_W]) : '0;
            sum_c = (SUM_W+1)'(old_c) + (SUM_W+1)'(n_reg[c]);
            if (sum_c[SUM_W] != sum_c[SUM_W-1])
                swr_data[c*SUM_W +: SUM_W] = sum_c[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                          : {1'b0, {(SUM_W-1){1'b1}}};
            else
                swr_data[c*SUM_W +: SUM_W] = sum_c[SUM_W-1:0];
        end
    end

    // Square root step.
    logic [ACC_W-1:0] sq_try;
    logic             sq_ge;
    assign sq_try = res_reg + bit_reg;
    assign sq_ge  = sqv_reg >= sq_try;

    // Divide step: one quotient bit a cycle against the vector length.
    logic [LEN_W-1:0] len;
    logic [LEN_W:0]   div_try;
    logic             div_ge;
    logic [15:0]      q_new;
    logic [15:0]      q_cap;
    logic [NUM_W-1:0] num;
    assign len     = res_reg[LEN_W-1:0];
    assign div_try = {rem_reg[LEN_W-1:0], numlo_reg[15]};
    assign div_ge  = div_try >= {1'b0, len};
    assign q_new   = {q_reg[14:0], div_ge};
    assign q_cap   = (q_new > 16'(UNIT_ONE)) ? 16'(UNIT_ONE) : q_new;
    assign num     = NUM_W'({mag_reg[j_reg][29:0], 14'd0}) + NUM_W'(res_reg[LEN_W-1:1]);

    logic [IDX_W-1:0] slot_idx;
    logic             slot_ok;
    assign slot_idx = slot_reg[IDX_W-1:0];
    assign slot_ok  = {1'b0, slot_reg} < 7'(MAX_VERTICES);

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_RD_DONE) && out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 5'd1;
        j_next     = j_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                j_next   = '0;
                if (in_acc && (in_cmd == CMD_TRI) && in_corners_ok)
                    state_next = ST_TRI_LD;
                else if (in_acc && (in_cmd == CMD_READ))
                    state_next = ST_RD_SUM;
            end
            ST_TRI_LD:
                if (cnt_reg == 5'd3)
                begin
                    state_next = ST_TRI_DIFF;
                    cnt_next   = '0;
                end
            ST_TRI_DIFF:
            begin
                state_next = ST_TRI_MUL;
                cnt_next   = '0;
            end
            ST_TRI_MUL:
                if (cnt_reg == 5'd7)
                begin
                    state_next = ST_TRI_RMW;
                    cnt_next   = '0;
                end
            ST_TRI_RMW:
                if (cnt_reg == 5'd5)
                    state_next = ST_IDLE;
            ST_RD_SUM:
                state_next = slot_ok ? ST_RD_MAG : ST_RD_DONE;
            ST_RD_MAG:
                state_next = ST_RD_MAX;
            ST_RD_MAX:
                state_next = ST_RD_SHIFT;
            ST_RD_SHIFT:
            begin
                cnt_next = '0;
                if (big_reg == '0)
                    state_next = ST_RD_DONE;
                else if ((big_reg < NORM_HI) && (big_reg >= NORM_LO))
                    state_next = ST_RD_SQ;
            end
            ST_RD_SQ:
                if (cnt_reg == 5'd4)
                begin
                    state_next = ST_RD_SQRT;
                    cnt_next   = '0;
                end
            ST_RD_SQRT:
                if (cnt_reg == 5'd30)
                    state_next = ST_RD_DSET;
            ST_RD_DSET:
            begin
                state_next = ST_RD_DIV;
                cnt_next   = '0;
            end
            ST_RD_DIV:
                if (cnt_reg == 5'd15)
                begin
                    if (j_reg == 2'd2)
                        state_next = ST_RD_DONE;
                    else
                    begin
                        state_next = ST_RD_DSET;
                        j_next     = j_reg + 2'd1;
                    end
                end
            ST_RD_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        logic [1:0] ld_corner;
        ld_corner = (cnt_reg[1:0] == 2'd3) ? 2'd0 : cnt_reg[1:0];
        s_tready  = (state_reg == ST_IDLE);
        vrd_addr  = corner_reg[ld_corner][IDX_W-1:0];
        srd_addr  = (state_reg == ST_TRI_RMW) ? corner_reg[rmw_corner][IDX_W-1:0] : slot_idx;
        swr_en    = (state_reg == ST_TRI_RMW) && cnt_reg[0];
        mac_ctrl  = '0;
        mac_a     = '0;
        mac_b     = '0;
        case (state_reg)
            ST_TRI_MUL:
            begin
                // nx = uy*vz - uz*vy, ny = uz*vx - ux*vz, nz = ux*vy - uy*vx
                case (cnt_reg)
                    5'd0:
                    begin
                        mac_a = MAC_W'(u_reg[1]);
                        mac_b = MAC_W'(v_reg[2]);
                    end
                    5'd1:
                    begin
                        mac_a = MAC_W'(u_reg[2]);
                        mac_b = MAC_W'(v_reg[1]);
                    end
                    5'd2:
                    begin
                        mac_a = MAC_W'(u_reg[2]);
                        mac_b = MAC_W'(v_reg[0]);
                    end
                    5'd3:
                    begin
                        mac_a = MAC_W'(u_reg[0]);
                        mac_b = MAC_W'(v_reg[2]);
                    end
                    5'd4:
                    begin
                        mac_a = MAC_W'(u_reg[0]);
                        mac_b = MAC_W'(v_reg[1]);
                    end
                    5'd5:
                    begin
                        mac_a = MAC_W'(u_reg[1]);
                        mac_b = MAC_W'(v_reg[0]);
                    end
                    default:
                    begin
                        mac_a = '0;
                        mac_b = '0;
                    end
                endcase
                mac_ctrl.acc_en   = (cnt_reg >= 5'd1) && (cnt_reg <= 5'd6);
                mac_ctrl.acc_load = cnt_reg[0];
                mac_ctrl.acc_sub  = !cnt_reg[0];
            end
            ST_RD_SQ:
            begin
                if (cnt_reg <= 5'd2)
                begin
                    mac_a = MAC_W'({2'b00, mag_reg[cnt_reg[1:0]][29:0]});
                    mac_b = mac_a;
                end
                mac_ctrl.acc_en   = (cnt_reg >= 5'd1) && (cnt_reg <= 5'd3);
                mac_ctrl.acc_load = (cnt_reg == 5'd1);
            end
            default:
                mac_ctrl = '0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            j_reg        <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            j_reg     <= j_next;
            if (in_acc && (in_cmd == CMD_CLEAR))
                valid_reg <= '0;
            else if (swr_en)
                valid_reg[srd_addr] <= 1'b1;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        logic [SUMS_W-1:0] sval;
        logic [SUM_W-1:0]  sc;
        sval = valid_reg[slot_idx] ? srd_reg : '0;
        case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    slot_reg <= in_slot;
                    for (int k = 0; k < 3; k++)
                        corner_reg[k] <= in_corner[k];
                end
            ST_TRI_LD:
                if (cnt_reg != 5'd0)
                    vtx_reg[cnt_reg[1:0] - 2'd1] <= vrd_reg;
            ST_TRI_DIFF:
                for (int c = 0; c < 3; c++)
                begin
                    u_reg[c] <= $signed({vtx_reg[1][c*CW+CW-1], vtx_reg[1][c*CW +: CW]})
                              - $signed({vtx_reg[0][c*CW+CW-1], vtx_reg[0][c*CW +: CW]});
                    v_reg[c] <= $signed({vtx_reg[2][c*CW+CW-1], vtx_reg[2][c*CW +: CW]})
                              - $signed({vtx_reg[0][c*CW+CW-1], vtx_reg[0][c*CW +: CW]});
                end
            ST_TRI_MUL:
                case (cnt_reg)
                    5'd3:    n_reg[0] <= mac_acc[N_W-1:0];
                    5'd5:    n_reg[1] <= mac_acc[N_W-1:0];
                    5'd7:    n_reg[2] <= mac_acc[N_W-1:0];
                    default: n_reg[0] <= n_reg[0];
                endcase
            ST_RD_SUM:
            begin
                zero_reg <= !slot_ok;
                for (int c = 0; c < 3; c++)
                    unit_reg[c] <= '0;
            end
            ST_RD_MAG:
                for (int c = 0; c < 3; c++)
                begin
                    sc = sval[c*SUM_W +: SUM_W];
                    sign_reg[c] <= sc[SUM_W-1];
                    mag_reg[c]  <= sc[SUM_W-1] ? MAG_W'(~sc + 1'b1) : MAG_W'(sc);
                end
            ST_RD_MAX:
                if ((mag_reg[0] >= mag_reg[1]) && (mag_reg[0] >= mag_reg[2]))
                    big_reg <= mag_reg[0];
                else if (mag_reg[1] >= mag_reg[2])
                    big_reg <= mag_reg[1];
                else
                    big_reg <= mag_reg[2];
            ST_RD_SHIFT:
                if (big_reg == '0)
                    zero_reg <= 1'b1;
                else if (big_reg >= NORM_HI)
                begin
                    big_reg <= big_reg >> 1;
                    for (int c = 0; c < 3; c++)
                        mag_reg[c] <= mag_reg[c] >> 1;
                end
                else if (big_reg < NORM_LO)
                begin
                    big_reg <= big_reg << 1;
                    for (int c = 0; c < 3; c++)
                        mag_reg[c] <= mag_reg[c] << 1;
                end
            ST_RD_SQ:
                if (cnt_reg == 5'd4)
                begin
                    sqv_reg <= ACC_W'(mac_acc);
                    res_reg <= '0;
                    bit_reg <= ACC_W'(1) << 60;
                end
            ST_RD_SQRT:
            begin
                if (sq_ge)
                begin
                    sqv_reg <= sqv_reg - sq_try;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            ST_RD_DSET:
            begin
                rem_reg   <= (LEN_W+1)'(num >> 16);
                numlo_reg <= num[15:0];
                q_reg     <= '0;
            end
            ST_RD_DIV:
            begin
                rem_reg   <= div_ge ? (div_try - {1'b0, len}) : div_try;
                numlo_reg <= numlo_reg << 1;
                q_reg     <= q_new;
                if (cnt_reg == 5'd15)
                    unit_reg[j_reg] <= sign_reg[j_reg] ? (~q_cap + 1'b1) : q_cap;
            end
            ST_RD_DONE:
                if (out_free)
                begin
                    m_tdata_reg <= {unit_reg[2], unit_reg[1], unit_reg[0]};
                    m_tuser_reg <= zero_reg;
                end
            default:
                zero_reg <= zero_reg;
        endcase
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule
`default_nettype wire

// File: rtl/vna_check.sv
`default_nettype none
module vna_check (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         s_tvalid,
    input wire                         s_tready,
    input wire [vna_pkg::IN_W-1:0]     s_tdata,
    input wire [vna_pkg::CMD_W-1:0]    s_tuser,
    input wire                         m_tvalid,
    input wire                         m_tready,
    input wire [vna_pkg::OUT_W-1:0]    m_tdata,
    input wire [0:0]                   m_tuser
);
    import vna_pkg::*;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input item changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("zero length result carries a nonzero normal");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16384) && ($signed(m_tdata[15:0]) >= -16384)
                  && ($signed(m_tdata[31:16]) <= 16384) && ($signed(m_tdata[31:16]) >= -16384)
                  && ($signed(m_tdata[47:32]) <= 16384) && ($signed(m_tdata[47:32]) >= -16384))
        else $error("normal component out of unit range");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_READ) |=> !s_tready)
        else $error("ready right after a read normal item");

endmodule

bind vertex_normal_accumulator_unit vna_check u_vna_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
